### rtl/fraction_reduce_mixed_macros.svh
// Assertion macros shared by the fraction reduction RTL.
`ifndef FRACTION_REDUCE_MIXED_MACROS_SVH
`define FRACTION_REDUCE_MIXED_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fraction_reduce_mixed: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fraction_reduce_mixed: next-cycle check failed");

`endif

### rtl/frm_pkg.sv
// Shared item types and result form codes for the fraction reduction block.
package frm_pkg;

   localparam int FieldWidth = 16;

   localparam logic [1:0] FORM_PROPER = 2'd0;
   localparam logic [1:0] FORM_MIXED  = 2'd1;
   localparam logic [1:0] FORM_WHOLE  = 2'd2;
   localparam logic [1:0] FORM_ERROR  = 2'd3;

   typedef struct packed {
      logic [FieldWidth-1:0] numerator;
      logic [FieldWidth-1:0] denominator;
   } req_item_type;

   typedef struct packed {
      logic [1:0]            form;
      logic [FieldWidth-1:0] whole_part;
      logic [FieldWidth-1:0] reduced_numerator;
      logic [FieldWidth-1:0] reduced_denominator;
   } rsp_item_type;

endpackage

### rtl/fraction_reduce_mixed.sv
// Top level of the fraction reduction block: sequencer, registers and result stage.
//
// Usage: an item on the req_ channel carries a numerator and a denominator. The block
// answers each item with exactly one item on the rsp_ channel, giving the form (proper,
// mixed, whole or error), the whole part and the fraction in lowest terms.
// Both channels move an item at a rising edge where valid is high and stall is low.
// The block takes one item at a time: req_stall is high from the accepting edge until
// the result has been moved into the output register.
// Work per item: accept, restoring division for the whole part and remainder, then a
// binary GCD of one step per cycle, then two more restoring divisions by the GCD, then
// load the result. A zero operand goes straight to the result load, and an exact
// quotient skips the GCD and the last two divisions. All of it runs through the one
// shared subtractor in frm_alu, which sets the pace.
// The output register lets a new item be accepted while a result is still stalled on
// rsp_; a finished result then waits until that register is free.
// Reset is synchronous and active high; it empties the block and drops rsp_valid.
`include "fraction_reduce_mixed_macros.svh"

module fraction_reduce_mixed #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  frm_pkg::req_item_type req_item,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output frm_pkg::rsp_item_type rsp_item
);

   import frm_pkg::*;

   localparam int W    = OPERAND_WIDTH;
   localparam int CntW = $clog2(OPERAND_WIDTH);

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_GCD  = 3'd2;
   localparam logic [2:0] ST_DIVN = 3'd3;
   localparam logic [2:0] ST_DIVD = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [W-1:0]    quo_ff, quo_in;
   logic [W-1:0]    rem_ff, rem_in;
   logic [W-1:0]    dv_ff, dv_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    num_ff, num_in;
   logic [W-1:0]    den_ff, den_in;
   logic [W-1:0]    whole_ff, whole_in;
   logic [1:0]      form_ff, form_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_item_ff, rsp_item_in;

   logic [W:0]      alu_x, alu_y, alu_diff;
   logic            alu_borrow, alu_zero;
   logic [W-1:0]    div_quo_nx, div_rem_nx;
   logic [W-1:0]    op_num, op_den;
   logic            req_accept, rsp_load;

   // The one arithmetic unit. GCD steps compare a against b; division steps
   // compare the shifted partial remainder against the divisor.
   always_comb begin
      if (state_ff == ST_GCD) begin
         alu_x = {1'b0, a_ff};
         alu_y = {1'b0, b_ff};
      end else begin
         alu_x = {rem_ff, quo_ff[W-1]};
         alu_y = {1'b0, dv_ff};
      end
   end

   frm_alu #(
      .WIDTH (W + 1)
   ) u_alu (
      .x      (alu_x),
      .y      (alu_y),
      .diff   (alu_diff),
      .borrow (alu_borrow),
      .zero   (alu_zero)
   );

   // One restoring division step: a quotient bit enters at the bottom of quo.
   always_comb begin
      if (alu_borrow) begin
         div_rem_nx = alu_x[W-1:0];
         div_quo_nx = {quo_ff[W-2:0], 1'b0};
      end else begin
         div_rem_nx = alu_diff[W-1:0];
         div_quo_nx = {quo_ff[W-2:0], 1'b1};
      end
   end

   assign op_num     = W'(req_item.numerator);
   assign op_den     = W'(req_item.denominator);
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dv_in    = dv_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      whole_in = whole_ff;
      form_in  = form_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               num_in   = op_num;
               den_in   = op_den;
               quo_in   = op_num;
               rem_in   = '0;
               dv_in    = op_den;
               cnt_in   = CntW'(W - 1);
               whole_in = '0;
               if (op_num == '0 || op_den == '0) begin
                  form_in  = FORM_ERROR;
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV1;
               end
            end
         end

         ST_DIV1: begin
            quo_in = div_quo_nx;
            rem_in = div_rem_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               whole_in = div_quo_nx;
               if (div_rem_nx == '0) begin
                  // Equal operands or an exact quotient.
                  form_in  = FORM_WHOLE;
                  state_in = ST_FIN;
               end else begin
                  // A proper fraction leaves quotient zero and remainder equal to
                  // the numerator, so both fraction cases reduce remainder over
                  // denominator.
                  form_in  = (div_quo_nx == '0) ? FORM_PROPER : FORM_MIXED;
                  num_in   = div_rem_nx;
                  a_in     = div_rem_nx;
                  b_in     = den_ff;
                  k_in     = '0;
                  state_in = ST_GCD;
               end
            end
         end

         ST_GCD: begin
            priority if (alu_zero) begin
               dv_in    = a_ff << k_ff;
               quo_in   = num_ff;
               rem_in   = '0;
               cnt_in   = CntW'(W - 1);
               state_in = ST_DIVN;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (alu_borrow) begin
               // Both odd with a below b: swap so the subtraction stays positive.
               a_in = b_ff;
               b_in = a_ff;
            end else begin
               a_in = alu_diff[W-1:0] >> 1;
            end
         end

         ST_DIVN: begin
            quo_in = div_quo_nx;
            rem_in = div_rem_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               num_in   = div_quo_nx;
               quo_in   = den_ff;
               rem_in   = '0;
               cnt_in   = CntW'(W - 1);
               state_in = ST_DIVD;
            end
         end

         ST_DIVD: begin
            quo_in = div_quo_nx;
            rem_in = div_rem_nx;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               den_in   = div_quo_nx;
               state_in = ST_FIN;
            end
         end

         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result assembly: fields that do not belong to the form read as zero.
   always_comb begin
      rsp_item_in = rsp_item_ff;
      if (rsp_load) begin
         rsp_item_in.form = form_ff;
         if (form_ff == FORM_MIXED || form_ff == FORM_WHOLE) begin
            rsp_item_in.whole_part = FieldWidth'(whole_ff);
         end else begin
            rsp_item_in.whole_part = '0;
         end
         if (form_ff == FORM_PROPER || form_ff == FORM_MIXED) begin
            rsp_item_in.reduced_numerator   = FieldWidth'(num_ff);
            rsp_item_in.reduced_denominator = FieldWidth'(den_ff);
         end else begin
            rsp_item_in.reduced_numerator   = '0;
            rsp_item_in.reduced_denominator = '0;
         end
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      dv_ff       <= dv_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      whole_ff    <= whole_in;
      form_ff     <= form_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The binary GCD never sees a zero operand, or it would not terminate.
   `FRM_ASSERT_NOW(a_gcd_nonzero, clock, reset, state_ff == ST_GCD,
                   a_ff != '0 && b_ff != '0)
   // A proper fraction stays proper after reduction.
   `FRM_ASSERT_NOW(a_proper_order, clock, reset,
                   rsp_valid && rsp_item.form == FORM_PROPER,
                   rsp_item.reduced_numerator < rsp_item.reduced_denominator)
   // Error results carry no numbers.
   `FRM_ASSERT_NOW(a_error_zero, clock, reset,
                   rsp_valid && rsp_item.form == FORM_ERROR,
                   rsp_item.whole_part == '0 && rsp_item.reduced_numerator == '0 &&
                   rsp_item.reduced_denominator == '0)
   // A newly loaded whole-number result has a nonzero quotient and no fraction.
   `FRM_ASSERT_NEXT(a_whole_shape, clock, reset, rsp_load && form_ff == FORM_WHOLE,
                    rsp_item.whole_part != '0 && rsp_item.reduced_numerator == '0)

endmodule

### rtl/frm_alu.sv
// Shared subtract and compare unit used by both the divider and the GCD steps.
module frm_alu #(
   parameter int WIDTH = 17
) (
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   output logic [WIDTH-1:0] diff,
   output logic             borrow,
   output logic             zero
);

   // The borrow out is set exactly when x is below y.
   assign {borrow, diff} = {1'b0, x} - {1'b0, y};
   assign zero = (diff == '0) && !borrow;

endmodule

### dv/testbench.sv
// Self-checking testbench for the fraction reduction block with a scoreboard class.
`timescale 1ns / 100ps

module testbench;
   import frm_pkg::*;

   // The watchdog fires after this many cycles with no item moved on either channel.
   // The limit sits well above the slowest correct item, the longest sender gap and the
   // receiver stall runs, so it leaves a wide margin.
   localparam int WatchdogLimit = 4000;
   // Cycles to wait after the last result, enough for any stray result to show up.
   localparam int DrainCycles   = 200;
   localparam int RandomItems   = 1000;
   localparam int MaxReported   = 10;

   // The scoreboard keeps one expected result per accepted item, in order. Because
   // the block answers every item with exactly one result, the oldest expectation
   // always belongs to the next result.
   class fraction_checker;
      req_item_type requests[$];
      rsp_item_type expected_results[$];
      int unsigned  mismatches = 0;

      // Euclid's algorithm on nonzero operands.
      function automatic logic [FieldWidth-1:0] euclid_gcd(logic [FieldWidth-1:0] a,
                                                           logic [FieldWidth-1:0] b);
         logic [FieldWidth-1:0] t;
         while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // Works out the lowest-terms form of one numerator/denominator item.
      function automatic rsp_item_type reduce_fraction(req_item_type item);
         logic [FieldWidth-1:0] n, d, q, r, g;
         rsp_item_type result;
         n = item.numerator;
         d = item.denominator;
         result = '0;
         result.form = FORM_ERROR;
         if (n != 0 && d != 0) begin
            q = n / d;
            r = n % d;
            if (n < d) begin
               g = euclid_gcd(n, d);
               result.form = FORM_PROPER;
               result.reduced_numerator = n / g;
               result.reduced_denominator = d / g;
            end else if (r != 0) begin
               // A mixed number: the remainder part is reduced against the denominator.
               g = euclid_gcd(r, d);
               result.form = FORM_MIXED;
               result.whole_part = q;
               result.reduced_numerator = r / g;
               result.reduced_denominator = d / g;
            end else begin
               result.form = FORM_WHOLE;
               result.whole_part = q;
            end
         end
         return result;
      endfunction

      function void note_request(req_item_type item);
         requests.push_back(item);
         expected_results.push_back(reduce_fraction(item));
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         req_item_type source;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("unexpected result: form %0d whole %0d fraction %0d/%0d",
                        got.form, got.whole_part, got.reduced_numerator,
                        got.reduced_denominator);
            return;
         end
         want = expected_results.pop_front();
         source = requests.pop_front();
         if (got.form !== want.form || got.whole_part !== want.whole_part ||
             got.reduced_numerator !== want.reduced_numerator ||
             got.reduced_denominator !== want.reduced_denominator) begin
            mismatches++;
            if (mismatches <= MaxReported)
               $display("mismatch %0d/%0d: expected %0d %0d %0d/%0d, got %0d %0d %0d/%0d",
                        source.numerator, source.denominator,
                        want.form, want.whole_part, want.reduced_numerator,
                        want.reduced_denominator, got.form, got.whole_part,
                        got.reduced_numerator, got.reduced_denominator);
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   fraction_checker reduction_check = new();

   // Sender burst bookkeeping and receiver stall pattern state.
   int unsigned burst_left  = 0;
   int unsigned stall_run   = 0;
   int unsigned cycle_count = 0;
   int unsigned idle_cycles = 0;
   bit          progress;

   fraction_reduce_mixed DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   // Offers one item and returns at the edge where it is accepted. The sender works
   // in bursts: when a burst runs out, it drops valid for a random gap and starts a
   // new burst of random length. A gap of zero gives back-to-back bursts.
   task automatic send_fraction(input logic [FieldWidth-1:0] numerator,
                                input logic [FieldWidth-1:0] denominator);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 9) < 3)
            gap = 0;
         else if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(41, 110);
         else
            gap = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item.numerator <= numerator;
      req_item.denominator <= denominator;
      // The stall seen right after the edge is the one that held at the edge.
      do @(posedge clock); while (req_stall);
   endtask

   // Holds the sender off until every expected result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (reduction_check.pending() != 0);
   endtask

   // Nearly half of the random items are shaped so that the GCD has real work to do: shared
   // factors, exact multiples and tiny values. The rest is full-range noise, zero
   // operands and values at the top of the range.
   function automatic req_item_type random_fraction();
      int unsigned  kind, common, lo, hi;
      req_item_type item;
      kind = $urandom_range(0, 99);
      item.numerator = FieldWidth'($urandom);
      item.denominator = FieldWidth'($urandom);
      if (kind >= 40 && kind < 65) begin
         common = $urandom_range(1, 300);
         item.numerator = FieldWidth'(common * $urandom_range(1, 200));
         item.denominator = FieldWidth'(common * $urandom_range(1, 200));
      end else if (kind >= 65 && kind < 80) begin
         lo = $urandom_range(1, 2000);
         item.denominator = FieldWidth'(lo);
         item.numerator = FieldWidth'(lo * $urandom_range(1, 65535 / lo));
      end else if (kind >= 80 && kind < 88) begin
         item.numerator = FieldWidth'($urandom_range(1, 16));
         item.denominator = FieldWidth'($urandom_range(1, 16));
      end else if (kind >= 88 && kind < 93) begin
         case ($urandom_range(0, 2))
            0: item.numerator = '0;
            1: item.denominator = '0;
            default: begin
               item.numerator = '0;
               item.denominator = '0;
            end
         endcase
      end else if (kind >= 93) begin
         hi = 65535 - $urandom_range(0, 3);
         lo = $urandom_range(1, 3);
         if ($urandom_range(0, 1)) begin
            item.numerator = FieldWidth'(hi);
            item.denominator = FieldWidth'(lo);
         end else begin
            item.numerator = FieldWidth'(lo);
            item.denominator = FieldWidth'(hi);
         end
      end
      return item;
   endfunction

   // Monitor, receiver and watchdog. Everything is sampled right after the rising
   // edge, before any nonblocking update of that edge lands, so the values seen are
   // the ones that decided the handshakes.
   always @(posedge clock) begin
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            reduction_check.note_request(req_item);
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            reduction_check.check_result(rsp_item);
            progress = 1'b1;
         end
      end

      // The receiver cycles through four stall patterns in turn: none at
      // all, light random stalls, heavy random stalls and long stall bursts.
      cycle_count++;
      case (cycle_count[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_run == 0 && $urandom_range(0, 7) == 0)
               stall_run = $urandom_range(1, 20);
            rsp_stall <= (stall_run != 0);
            if (stall_run != 0)
               stall_run--;
         end
      endcase

      if (!reset) begin
         if (progress)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      req_item_type item;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items: zero operands, equal operands, the field extremes, proper,
      // mixed and whole forms, and fractions with large common factors.
      send_fraction(16'd0, 16'd0);
      send_fraction(16'd0, 16'd7);
      send_fraction(16'd9, 16'd0);
      send_fraction(16'd1, 16'd1);
      send_fraction(16'd65535, 16'd65535);
      send_fraction(16'd1, 16'd65535);
      send_fraction(16'd65535, 16'd1);
      send_fraction(16'd65534, 16'd65535);
      send_fraction(16'd65535, 16'd65534);
      send_fraction(16'd1, 16'd2);
      send_fraction(16'd3, 16'd2);
      send_fraction(16'd12, 16'd18);
      send_fraction(16'd36, 16'd48);
      send_fraction(16'd48, 16'd36);
      send_fraction(16'd7, 16'd3);
      send_fraction(16'd100, 16'd10);
      send_fraction(16'd65535, 16'd2);
      send_fraction(16'd32768, 16'd2);
      send_fraction(16'd2, 16'd32768);
      send_fraction(16'd43690, 16'd21845);
      send_fraction(16'd21845, 16'd43690);
      send_fraction(16'd32768, 16'd24576);
      wait_for_drain();

      // Random items, with the sender held off a few times until all results are in.
      for (int i = 0; i < RandomItems; i++) begin
         item = random_fraction();
         send_fraction(item.numerator, item.denominator);
         if (i % 250 == 249)
            wait_for_drain();
      end
      wait_for_drain();

      // Give the block time to show any result that nobody asked for.
      repeat (DrainCycles) @(posedge clock);
      if (reduction_check.mismatches == 0 && reduction_check.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
